/* rtl/ecg_pkg.sv */
// ----------------------------------------------------------------------------
// ElGamal engine package
// Shared constants, register indexes, controller states and the command and
// status bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ecg_pkg;

  // Fixed field widths of the stream payload and the configuration data.
  localparam int unsigned FIELD_W      = 20;
  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned MOD_BITS_DEF = 20;
  localparam int unsigned CFG_IDX_W    = 2;

  localparam logic [FIELD_W-1:0] MODULUS_RST = 20'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GENERATOR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PUBLIC    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PRIVATE   = 2'd3;

  // Request and result kinds.
  localparam logic REQ_ENCRYPT = 1'b0;
  localparam logic REQ_DECRYPT = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_RED_W,
    ST_EXP,
    ST_ACC_W,
    ST_SQR_W,
    ST_POST,
    ST_FIN_W,
    ST_OUT
  } ecg_state_e;

  // Operation of the shared modular multiplier.
  typedef enum logic [1:0] {
    MOP_REDUCE,
    MOP_ACC,
    MOP_SQR,
    MOP_FINAL
  } ecg_mop_e;

  // Base of an exponentiation.
  typedef enum logic [1:0] {
    BASE_GEN,
    BASE_PUB,
    BASE_CIPHER
  } ecg_base_e;

  typedef struct packed {
    logic      load;
    logic      init_exp;
    logic      mul_start;
    ecg_mop_e  mul_op;
    ecg_base_e base_sel;
    logic      e_shift;
    logic      save_first;
    logic      emit;
  } ecg_cmd_t;

  typedef struct packed {
    logic skip;
    logic decrypt;
    logic e_zero;
    logic e_lsb;
    logic e_upper_zero;
    logic mul_done;
  } ecg_sts_t;

endpackage

/* rtl/ecg_mulmod.sv */
// ----------------------------------------------------------------------------
// Serial modular multiplier
// Interleaved shift-and-add product x*y mod p, one bit of x per cycle from the
// top bit down. y must already be below p; x may be any value.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ecg_mulmod #(
  parameter int unsigned MOD_BITS = ecg_pkg::MOD_BITS_DEF,
  parameter int unsigned X_BITS   = ecg_pkg::FIELD_W
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [X_BITS-1:0]   x_i,
  input  logic [MOD_BITS-1:0] y_i,
  input  logic [MOD_BITS-1:0] p_i,
  output logic                done_o,
  output logic [MOD_BITS-1:0] res_o
);

  localparam int unsigned CNT_W = $clog2(X_BITS + 1);
  localparam int unsigned T_W   = MOD_BITS + 2;

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [X_BITS-1:0]   x_q, x_d;
  logic [MOD_BITS-1:0] y_q, y_d;
  logic [MOD_BITS-1:0] acc_q, acc_d;

  logic [T_W-1:0] t_sum;
  logic [T_W-1:0] p_one;
  logic [T_W-1:0] p_two;
  logic [T_W-1:0] t_red;

  // With acc and y below p the sum stays below 3p, so at most two
  // subtractions bring it back into range.
  always_comb begin
    p_one = {2'b00, p_i};
    p_two = {1'b0, p_i, 1'b0};
    t_sum = {1'b0, acc_q, 1'b0} + (x_q[X_BITS-1] ? {2'b00, y_q} : '0);
    if (t_sum >= p_two) begin
      t_red = t_sum - p_two;
    end else if (t_sum >= p_one) begin
      t_red = t_sum - p_one;
    end else begin
      t_red = t_sum;
    end
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    x_d    = x_q;
    y_d    = y_q;
    acc_d  = acc_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(X_BITS);
      x_d    = x_i;
      y_d    = y_i;
      acc_d  = '0;
    end else if (busy_q) begin
      acc_d = t_red[MOD_BITS-1:0];
      x_d   = {x_q[X_BITS-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    y_q   <= y_d;
    acc_q <= acc_d;
  end

  assign done_o = done_q;
  assign res_o  = acc_q;

endmodule

/* rtl/ecg_datapath.sv */
// ----------------------------------------------------------------------------
// ElGamal datapath
// Key registers, the captured request, the exponent shift register, the
// square-and-multiply accumulators around the shared modular multiplier,
// and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ecg_datapath #(
  parameter int unsigned MOD_BITS = ecg_pkg::MOD_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ecg_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ecg_pkg::FIELD_W-1:0]    cfg_data_i,
  input  logic                           req_type_i,
  input  logic [ecg_pkg::BYTE_W-1:0]     plain_byte_i,
  input  logic [ecg_pkg::FIELD_W-1:0]    nonce_i,
  input  logic [ecg_pkg::FIELD_W-1:0]    cipher_first_i,
  input  logic [ecg_pkg::FIELD_W-1:0]    cipher_second_i,
  input  ecg_pkg::ecg_cmd_t              cmd_i,
  output ecg_pkg::ecg_sts_t              sts_o,
  output logic                           result_kind_o,
  output logic [ecg_pkg::FIELD_W-1:0]    out_first_o,
  output logic [ecg_pkg::FIELD_W-1:0]    out_second_o,
  output logic [ecg_pkg::BYTE_W-1:0]     out_byte_o
);

  localparam int unsigned FW = ecg_pkg::FIELD_W;
  localparam int unsigned BW = ecg_pkg::BYTE_W;
  localparam int unsigned EW = (MOD_BITS > FW) ? MOD_BITS : FW;

  // Key registers
  logic [MOD_BITS-1:0] p_q, g_q, y_q, x_q;
  logic [EW-1:0]       cfg_ext;
  logic [EW-1:0]       mod_rst_ext;

  // Captured request
  logic          req_q;
  logic [BW-1:0] byte_q;
  logic [FW-1:0] nonce_q, ca_q, cb_q;

  // Exponentiation state
  logic [EW-1:0]       e_q, e_d;
  logic [MOD_BITS-1:0] acc_q, acc_d;
  logic [MOD_BITS-1:0] sq_q, sq_d;
  logic [MOD_BITS-1:0] c1_q;
  ecg_pkg::ecg_mop_e   op_q;

  // Output register
  logic          kind_q;
  logic [FW-1:0] first_q, second_q;
  logic [BW-1:0] byte_out_q;

  logic [MOD_BITS-1:0] one_mod;
  logic [MOD_BITS-1:0] p_minus1;
  logic [MOD_BITS-1:0] dec_exp;
  logic [EW-1:0]       base_x;
  logic [EW-1:0]       mul_x;
  logic [MOD_BITS-1:0] mul_y;
  logic                mul_done;
  logic [MOD_BITS-1:0] mul_res;
  logic [EW-1:0]       acc_ext, c1_ext;

  assign cfg_ext     = EW'(cfg_data_i);
  assign mod_rst_ext = EW'(ecg_pkg::MODULUS_RST);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_q <= mod_rst_ext[MOD_BITS-1:0];
      g_q <= '0;
      y_q <= '0;
      x_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        ecg_pkg::CFG_MODULUS:   p_q <= cfg_ext[MOD_BITS-1:0];
        ecg_pkg::CFG_GENERATOR: g_q <= cfg_ext[MOD_BITS-1:0];
        ecg_pkg::CFG_PUBLIC:    y_q <= cfg_ext[MOD_BITS-1:0];
        ecg_pkg::CFG_PRIVATE:   x_q <= cfg_ext[MOD_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q   <= req_type_i;
      byte_q  <= plain_byte_i;
      nonce_q <= nonce_i;
      ca_q    <= cipher_first_i;
      cb_q    <= cipher_second_i;
    end
  end

  // Every residue is zero when the modulus is below two.
  assign one_mod  = {{(MOD_BITS-1){1'b0}}, (p_q > MOD_BITS'(1))};
  assign p_minus1 = p_q - MOD_BITS'(1);
  // A private exponent at or above p-1 leaves an empty exponent, so the
  // power is one.
  assign dec_exp  = ((p_q != '0) && (x_q < p_minus1)) ? (p_minus1 - x_q) : '0;

  always_comb begin
    case (cmd_i.base_sel)
      ecg_pkg::BASE_GEN:    base_x = EW'(g_q);
      ecg_pkg::BASE_PUB:    base_x = EW'(y_q);
      ecg_pkg::BASE_CIPHER: base_x = EW'(ca_q);
      default:              base_x = '0;
    endcase
  end

  always_comb begin
    case (cmd_i.mul_op)
      ecg_pkg::MOP_REDUCE: begin
        mul_x = base_x;
        mul_y = one_mod;
      end
      ecg_pkg::MOP_ACC: begin
        mul_x = EW'(acc_q);
        mul_y = sq_q;
      end
      ecg_pkg::MOP_SQR: begin
        mul_x = EW'(sq_q);
        mul_y = sq_q;
      end
      ecg_pkg::MOP_FINAL: begin
        mul_x = (req_q == ecg_pkg::REQ_DECRYPT) ? EW'(cb_q) : EW'(byte_q);
        mul_y = acc_q;
      end
      default: begin
        mul_x = '0;
        mul_y = '0;
      end
    endcase
  end

  ecg_mulmod #(
    .MOD_BITS (MOD_BITS),
    .X_BITS   (EW)
  ) u_mulmod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mul_start),
    .x_i     (mul_x),
    .y_i     (mul_y),
    .p_i     (p_q),
    .done_o  (mul_done),
    .res_o   (mul_res)
  );

  always_comb begin
    e_d   = e_q;
    acc_d = acc_q;
    sq_d  = sq_q;
    if (cmd_i.init_exp) begin
      e_d   = (req_q == ecg_pkg::REQ_DECRYPT) ? EW'(dec_exp) : EW'(nonce_q);
      acc_d = one_mod;
    end else if (cmd_i.e_shift) begin
      e_d = {1'b0, e_q[EW-1:1]};
    end
    if (mul_done) begin
      case (op_q)
        ecg_pkg::MOP_REDUCE: sq_d  = mul_res;
        ecg_pkg::MOP_SQR:    sq_d  = mul_res;
        ecg_pkg::MOP_ACC:    acc_d = mul_res;
        ecg_pkg::MOP_FINAL:  acc_d = mul_res;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    e_q   <= e_d;
    acc_q <= acc_d;
    sq_q  <= sq_d;
    if (cmd_i.mul_start) begin
      op_q <= cmd_i.mul_op;
    end
    if (cmd_i.save_first) begin
      c1_q <= acc_q;
    end
  end

  assign acc_ext = EW'(acc_q);
  assign c1_ext  = EW'(c1_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      kind_q <= req_q;
      if (req_q == ecg_pkg::REQ_DECRYPT) begin
        first_q    <= '0;
        second_q   <= '0;
        byte_out_q <= acc_q[BW-1:0];
      end else begin
        first_q    <= c1_ext[FW-1:0];
        second_q   <= acc_ext[FW-1:0];
        byte_out_q <= '0;
      end
    end
  end

  assign sts_o.skip = (req_q == ecg_pkg::REQ_DECRYPT) ?
                      ((ca_q == '0) || (cb_q == '0)) :
                      ((byte_q == '0) || byte_q[BW-1]);
  assign sts_o.decrypt      = (req_q == ecg_pkg::REQ_DECRYPT);
  assign sts_o.e_zero       = (e_q == '0);
  assign sts_o.e_lsb        = e_q[0];
  assign sts_o.e_upper_zero = (e_q[EW-1:1] == '0);
  assign sts_o.mul_done     = mul_done;

  assign result_kind_o = kind_q;
  assign out_first_o   = first_q;
  assign out_second_o  = second_q;
  assign out_byte_o    = byte_out_q;

endmodule

/* rtl/ecg_ctrl.sv */
// ----------------------------------------------------------------------------
// ElGamal controller
// Sequences the request through base reduction, right-to-left
// square-and-multiply and the final product, and owns the output valid.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ecg_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  ecg_pkg::ecg_sts_t sts_i,
  output ecg_pkg::ecg_cmd_t cmd_o
);

  ecg_pkg::ecg_state_e state_q, state_d;
  logic                second_q, second_d;
  logic                valid_q, valid_d;
  logic                out_free;

  assign out_free = !valid_q || out_ready_i;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ecg_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = ecg_pkg::ST_CHECK;
      end
      ecg_pkg::ST_CHECK: begin
        state_d = sts_i.skip ? ecg_pkg::ST_IDLE : ecg_pkg::ST_RED_W;
      end
      ecg_pkg::ST_RED_W: begin
        if (sts_i.mul_done) state_d = ecg_pkg::ST_EXP;
      end
      ecg_pkg::ST_EXP: begin
        if (sts_i.e_zero) begin
          state_d = ecg_pkg::ST_POST;
        end else if (sts_i.e_lsb) begin
          state_d = ecg_pkg::ST_ACC_W;
        end else begin
          state_d = ecg_pkg::ST_SQR_W;
        end
      end
      ecg_pkg::ST_ACC_W: begin
        if (sts_i.mul_done) begin
          state_d = sts_i.e_upper_zero ? ecg_pkg::ST_POST : ecg_pkg::ST_SQR_W;
        end
      end
      ecg_pkg::ST_SQR_W: begin
        if (sts_i.mul_done) state_d = ecg_pkg::ST_EXP;
      end
      ecg_pkg::ST_POST: begin
        if (!sts_i.decrypt && !second_q) begin
          state_d = ecg_pkg::ST_RED_W;
        end else begin
          state_d = ecg_pkg::ST_FIN_W;
        end
      end
      ecg_pkg::ST_FIN_W: begin
        if (sts_i.mul_done) state_d = ecg_pkg::ST_OUT;
      end
      ecg_pkg::ST_OUT: begin
        if (out_free) state_d = ecg_pkg::ST_IDLE;
      end
      default: state_d = ecg_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o            = '0;
    cmd_o.mul_op     = ecg_pkg::MOP_REDUCE;
    cmd_o.base_sel   = ecg_pkg::BASE_GEN;
    in_ready_o       = 1'b0;
    case (state_q)
      ecg_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ecg_pkg::ST_CHECK: begin
        if (!sts_i.skip) begin
          cmd_o.init_exp  = 1'b1;
          cmd_o.mul_start = 1'b1;
          cmd_o.base_sel  = sts_i.decrypt ? ecg_pkg::BASE_CIPHER : ecg_pkg::BASE_GEN;
        end
      end
      ecg_pkg::ST_EXP: begin
        if (!sts_i.e_zero) begin
          cmd_o.mul_start = 1'b1;
          cmd_o.mul_op    = sts_i.e_lsb ? ecg_pkg::MOP_ACC : ecg_pkg::MOP_SQR;
        end
      end
      ecg_pkg::ST_ACC_W: begin
        if (sts_i.mul_done && !sts_i.e_upper_zero) begin
          cmd_o.mul_start = 1'b1;
          cmd_o.mul_op    = ecg_pkg::MOP_SQR;
        end
      end
      ecg_pkg::ST_SQR_W: begin
        cmd_o.e_shift = sts_i.mul_done;
      end
      ecg_pkg::ST_POST: begin
        cmd_o.mul_start = 1'b1;
        if (!sts_i.decrypt && !second_q) begin
          // First ciphertext part is done; start on the public key power.
          cmd_o.save_first = 1'b1;
          cmd_o.init_exp   = 1'b1;
          cmd_o.base_sel   = ecg_pkg::BASE_PUB;
        end else begin
          cmd_o.mul_op = ecg_pkg::MOP_FINAL;
        end
      end
      ecg_pkg::ST_OUT: begin
        cmd_o.emit = out_free;
      end
      default: ;
    endcase
  end

  always_comb begin
    second_d = second_q;
    if (cmd_o.load) begin
      second_d = 1'b0;
    end else if (cmd_o.save_first) begin
      second_d = 1'b1;
    end
    valid_d = valid_q;
    if (cmd_o.emit) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ecg_pkg::ST_IDLE;
      second_q <= 1'b0;
      valid_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      second_q <= second_d;
      valid_q  <= valid_d;
    end
  end

  assign out_valid_o = valid_q;

endmodule

/* rtl/elgamal_cipher_engine_top.sv */
// ----------------------------------------------------------------------------
// ElGamal cipher engine top level
// Each product runs on the one serial multiplier. Transactions are taken
// one at a time; a result waits in the output register while the next
// transaction is taken.
// Reset clears the control state and sets the modulus to 2.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module elgamal_cipher_engine_top #(
  parameter int unsigned MOD_BITS = ecg_pkg::MOD_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ecg_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ecg_pkg::FIELD_W-1:0]   cfg_data_i,
  // Request stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // plain_byte[7:0], nonce[27:8], cipher_first[47:28], cipher_second[67:48],
  // zero padding[71:68]
  input  logic [71:0]                   s_axis_tdata,
  // req_type[0]
  input  logic [0:0]                    s_axis_tuser,
  // Result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // out_first[19:0], out_second[39:20], out_byte[47:40]
  output logic [47:0]                   m_axis_tdata,
  // result_kind[0]
  output logic [0:0]                    m_axis_tuser
);

  ecg_pkg::ecg_cmd_t cmd;
  ecg_pkg::ecg_sts_t sts;

  logic                         result_kind;
  logic [ecg_pkg::FIELD_W-1:0]  out_first;
  logic [ecg_pkg::FIELD_W-1:0]  out_second;
  logic [ecg_pkg::BYTE_W-1:0]   out_byte;

  assign cfg_ready_o = 1'b1;

  ecg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ecg_datapath #(
    .MOD_BITS (MOD_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .req_type_i      (s_axis_tuser[0]),
    .plain_byte_i    (s_axis_tdata[7:0]),
    .nonce_i         (s_axis_tdata[27:8]),
    .cipher_first_i  (s_axis_tdata[47:28]),
    .cipher_second_i (s_axis_tdata[67:48]),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .result_kind_o   (result_kind),
    .out_first_o     (out_first),
    .out_second_o    (out_second),
    .out_byte_o      (out_byte)
  );

  assign m_axis_tdata = {out_byte, out_second, out_first};
  assign m_axis_tuser = result_kind;

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// ElGamal cipher engine testbench
// Drives encrypt and decrypt requests into the request stream under several
// key settings, including degenerate and out-of-range ones. Every result
// transaction is checked field by field against a modular-arithmetic
// predictor or, for directed rows, against a given result. A short table of
// directed requests comes first, followed by random traffic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  localparam int unsigned FW = ecg_pkg::FIELD_W;
  localparam int unsigned BW = ecg_pkg::BYTE_W;
  localparam int unsigned IW = ecg_pkg::CFG_IDX_W;

  localparam logic KIND_PAIR = 1'b0;
  localparam logic KIND_BYTE = 1'b1;

  localparam int unsigned IDLE_WAIT       = 2500;
  localparam int unsigned CYCLE_LIMIT     = 20000000;
  localparam int unsigned ANSWERS_PER_SET = 80;
  localparam int unsigned KEY_SETS        = 6;

  typedef struct packed {
    logic          req_type;
    logic [BW-1:0] plain_byte;
    logic [FW-1:0] nonce;
    logic [FW-1:0] cipher_first;
    logic [FW-1:0] cipher_second;
  } elg_request_t;

  typedef struct packed {
    logic          kind;
    logic [FW-1:0] out_first;
    logic [FW-1:0] out_second;
    logic [BW-1:0] out_byte;
  } elg_result_t;

  typedef enum logic {ROW_WRITE, ROW_SEND} row_kind_e;
  typedef enum logic [1:0] {CHK_MODEL, CHK_GIVEN, CHK_NONE} row_check_e;

  typedef struct {
    row_kind_e     kind;
    logic [IW-1:0] idx;
    logic [FW-1:0] value;
    elg_request_t  req;
    row_check_e    chk;
    elg_result_t   given;
  } stim_row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [IW-1:0]        cfg_index_i;
  logic [FW-1:0]        cfg_data_i;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [71:0]          s_axis_tdata;
  logic [0:0]           s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [47:0]          m_axis_tdata;
  logic [0:0]           m_axis_tuser;

  // Key registers as the engine should hold them.
  logic [FW-1:0] key_modulus;
  logic [FW-1:0] key_generator;
  logic [FW-1:0] key_public;
  logic [FW-1:0] key_private;

  elg_result_t expected_results[$];
  stim_row_t   stim_rows[$];
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  bit          sent_since_settle;

  elgamal_cipher_engine_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial clk_i = 1'b0;
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [63:0] reduce_mod(logic [63:0] v, logic [63:0] p);
    if (p < 64'd2) return 64'd0;
    return v % p;
  endfunction

  function automatic logic [63:0] mul_mod(logic [63:0] a, logic [63:0] b, logic [63:0] p);
    return reduce_mod(reduce_mod(a, p) * reduce_mod(b, p), p);
  endfunction

  function automatic logic [63:0] power_mod(logic [63:0] base, logic [63:0] e,
                                            logic [63:0] p);
    logic [63:0] acc;
    logic [63:0] sq;
    acc = reduce_mod(64'd1, p);
    sq  = reduce_mod(base, p);
    for (int i = 0; i < 32; i++) begin
      if (e[i]) acc = mul_mod(acc, sq, p);
      sq = mul_mod(sq, sq, p);
    end
    return acc;
  endfunction

  // Returns 1 when the request produces a result, with that result in res.
  function automatic bit elgamal_answer(elg_request_t r, output elg_result_t res);
    logic [63:0] p;
    logic [63:0] pw;
    logic [63:0] plain;
    p   = 64'(key_modulus);
    res = '0;
    if (r.req_type == ecg_pkg::REQ_ENCRYPT) begin
      if (r.plain_byte < 8'd1 || r.plain_byte > 8'd127) return 1'b0;
      res.kind       = KIND_PAIR;
      res.out_first  = FW'(power_mod(64'(key_generator), 64'(r.nonce), p));
      res.out_second = FW'(mul_mod(power_mod(64'(key_public), 64'(r.nonce), p),
                                   64'(r.plain_byte), p));
    end else begin
      if (r.cipher_first == '0 || r.cipher_second == '0) return 1'b0;
      // A private exponent of p-1 or more leaves a zero or negative power.
      if (p < 64'd1 || 64'(key_private) >= p - 64'd1)
        pw = reduce_mod(64'd1, p);
      else
        pw = power_mod(64'(r.cipher_first), p - 64'd1 - 64'(key_private), p);
      plain        = mul_mod(64'(r.cipher_second), pw, p);
      res.kind     = KIND_BYTE;
      res.out_byte = plain[BW-1:0];
    end
    return 1'b1;
  endfunction

  // ------------------------------------------------------------ table helpers

  function automatic elg_request_t mk_req(logic t, logic [7:0] b, logic [19:0] k,
                                          logic [19:0] a, logic [19:0] c);
    elg_request_t r;
    r.req_type      = t;
    r.plain_byte    = b;
    r.nonce         = k;
    r.cipher_first  = a;
    r.cipher_second = c;
    return r;
  endfunction

  function automatic elg_result_t mk_res(logic kind, logic [19:0] f, logic [19:0] s,
                                         logic [7:0] b);
    elg_result_t r;
    r.kind       = kind;
    r.out_first  = f;
    r.out_second = s;
    r.out_byte   = b;
    return r;
  endfunction

  function automatic stim_row_t write_row(logic [IW-1:0] idx, logic [19:0] v);
    stim_row_t row;
    row.kind  = ROW_WRITE;
    row.idx   = idx;
    row.value = v;
    row.req   = '0;
    row.chk   = CHK_NONE;
    row.given = '0;
    return row;
  endfunction

  function automatic stim_row_t send_row(elg_request_t r, row_check_e chk,
                                         elg_result_t given);
    stim_row_t row;
    row.kind  = ROW_SEND;
    row.idx   = '0;
    row.value = '0;
    row.req   = r;
    row.chk   = chk;
    row.given = given;
    return row;
  endfunction

  function automatic void add_row(stim_row_t row);
    stim_rows.insert(stim_rows.size(), row);
  endfunction

  function automatic void expect_result(elg_result_t res);
    expected_results.insert(expected_results.size(), res);
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 20);
    if (roll < 99) return $urandom_range(50, 200);
    return $urandom_range(500, 2500);
  endfunction

  function automatic int unsigned pick_stall();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return $urandom_range(1, 3);
    if (roll < 95) return $urandom_range(4, 20);
    return $urandom_range(100, 2500);
  endfunction

  function automatic logic [19:0] pick_nonce();
    if ($urandom_range(0, 99) < 70) return 20'($urandom_range(0, 255));
    return 20'($urandom);
  endfunction

  // ------------------------------------------------------------------ drivers

  // Lowers the request valid and, if requests went in, waits until every
  // result is back and the engine has had time to finish silent requests.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    if (sent_since_settle) begin
      while (expected_results.size() != 0) @(posedge clk_i);
      repeat (IDLE_WAIT) @(posedge clk_i);
      sent_since_settle = 1'b0;
    end
  endtask

  task automatic write_register(logic [IW-1:0] idx, logic [FW-1:0] v);
    settle();
    cfg_index_i <= idx;
    cfg_data_i  <= v;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      ecg_pkg::CFG_MODULUS:   key_modulus   = v;
      ecg_pkg::CFG_GENERATOR: key_generator = v;
      ecg_pkg::CFG_PUBLIC:    key_public    = v;
      ecg_pkg::CFG_PRIVATE:   key_private   = v;
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Valid stays high after the transaction so that a following request with
  // no gap goes out back to back; the next call lowers it when it idles.
  task automatic send_request(elg_request_t r, bit hold);
    int unsigned gap;
    gap = pick_gap();
    if (hold && gap == 0) gap = 1;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      if (hold) while (expected_results.size() != 0) @(posedge clk_i);
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata  <= {4'b0000, r.cipher_second, r.cipher_first, r.nonce, r.plain_byte};
    s_axis_tuser  <= r.req_type;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    sent_since_settle = 1'b1;
  endtask

  // Result-side back-pressure: mostly short stalls, now and then a long one,
  // and stretches where the sink never stalls.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      m_axis_tready <= 1'b1;
      if ($urandom_range(0, 99) < 15) begin
        repeat ($urandom_range(500, 3000)) @(posedge clk_i);
      end else begin
        repeat ($urandom_range(1, 30)) @(posedge clk_i);
        m_axis_tready <= 1'b0;
        repeat (pick_stall()) @(posedge clk_i);
      end
    end
  end

  // ------------------------------------------------------------------ checker

  always @(posedge clk_i) begin
    elg_result_t got;
    elg_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.kind       = m_axis_tuser[0];
      got.out_first  = m_axis_tdata[19:0];
      got.out_second = m_axis_tdata[39:20];
      got.out_byte   = m_axis_tdata[47:40];
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: kind=%0d first=%h second=%h byte=%h",
                   got.kind, got.out_first, got.out_second, got.out_byte);
      end else begin
        want = expected_results.pop_front();
        if (got.kind !== want.kind || got.out_first !== want.out_first ||
            got.out_second !== want.out_second || got.out_byte !== want.out_byte) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"result mismatch: expected kind=%0d first=%h second=%h byte=%h,",
                      " got kind=%0d first=%h second=%h byte=%h"},
                     want.kind, want.out_first, want.out_second, want.out_byte,
                     got.kind, got.out_first, got.out_second, got.out_byte);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // ----------------------------------------------------------------- stimulus

  initial begin
    elg_request_t r;
    elg_result_t  res;
    logic [19:0]  p, g, y, x;
    logic [19:0]  k;
    logic [7:0]   m;
    int unsigned  answered;
    int unsigned  choice;

    sent_since_settle = 1'b0;
    cfg_valid_i       = 1'b0;
    cfg_index_i       = '0;
    cfg_data_i        = '0;
    s_axis_tvalid     = 1'b0;
    s_axis_tdata      = '0;
    s_axis_tuser      = '0;
    key_modulus       = ecg_pkg::MODULUS_RST;
    key_generator     = '0;
    key_public        = '0;
    key_private       = '0;
    rst_ni            = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset keys: p = 2, everything else zero.
    add_row(send_row(mk_req(ecg_pkg::REQ_ENCRYPT, 8'd1, 20'd0, 20'd0, 20'd0), CHK_GIVEN,
                     mk_res(KIND_PAIR, 20'd1, 20'd1, 8'd0)));
    add_row(send_row(mk_req(ecg_pkg::REQ_ENCRYPT, 8'd127, 20'hFFFFF, 20'd0, 20'd0),
                     CHK_GIVEN, mk_res(KIND_PAIR, 20'd0, 20'd0, 8'd0)));
    // Bytes outside 1..127 and zero ciphertext parts are dropped silently.
    add_row(send_row(mk_req(ecg_pkg::REQ_ENCRYPT, 8'd0, 20'd5, 20'd0, 20'd0),
                     CHK_NONE, '0));
    add_row(send_row(mk_req(ecg_pkg::REQ_ENCRYPT, 8'd128, 20'd5, 20'd0, 20'd0),
                     CHK_NONE, '0));
    add_row(send_row(mk_req(ecg_pkg::REQ_ENCRYPT, 8'd255, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF),
                     CHK_NONE, '0));
    add_row(send_row(mk_req(ecg_pkg::REQ_DECRYPT, 8'd9, 20'd0, 20'd0, 20'd5),
                     CHK_NONE, '0));
    add_row(send_row(mk_req(ecg_pkg::REQ_DECRYPT, 8'd9, 20'd0, 20'd5, 20'd0),
                     CHK_NONE, '0));
    add_row(send_row(mk_req(ecg_pkg::REQ_DECRYPT, 8'hFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF),
                     CHK_GIVEN, mk_res(KIND_BYTE, 20'd0, 20'd0, 8'd1)));
    // Moduli below two reduce every residue to zero.
    add_row(write_row(ecg_pkg::CFG_MODULUS, 20'd0));
    add_row(send_row(mk_req(ecg_pkg::REQ_ENCRYPT, 8'd5, 20'd3, 20'd0, 20'd0), CHK_GIVEN,
                     mk_res(KIND_PAIR, 20'd0, 20'd0, 8'd0)));
    add_row(send_row(mk_req(ecg_pkg::REQ_DECRYPT, 8'd0, 20'd0, 20'd1, 20'd1), CHK_GIVEN,
                     mk_res(KIND_BYTE, 20'd0, 20'd0, 8'd0)));
    add_row(write_row(ecg_pkg::CFG_MODULUS, 20'd1));
    add_row(send_row(mk_req(ecg_pkg::REQ_DECRYPT, 8'd0, 20'd0, 20'hFFFFF, 20'hFFFFF),
                     CHK_GIVEN, mk_res(KIND_BYTE, 20'd0, 20'd0, 8'd0)));
    add_row(send_row(mk_req(ecg_pkg::REQ_ENCRYPT, 8'd127, 20'd0, 20'd0, 20'd0), CHK_GIVEN,
                     mk_res(KIND_PAIR, 20'd0, 20'd0, 8'd0)));
    // Largest 20-bit prime; all-ones key words reduce to 2.
    add_row(write_row(ecg_pkg::CFG_MODULUS, 20'd1048573));
    add_row(write_row(ecg_pkg::CFG_GENERATOR, 20'hFFFFF));
    add_row(write_row(ecg_pkg::CFG_PUBLIC, 20'hFFFFF));
    add_row(write_row(ecg_pkg::CFG_PRIVATE, 20'hFFFFF));
    add_row(send_row(mk_req(ecg_pkg::REQ_DECRYPT, 8'd0, 20'd0, 20'd7, 20'd300), CHK_GIVEN,
                     mk_res(KIND_BYTE, 20'd0, 20'd0, 8'd44)));
    add_row(send_row(mk_req(ecg_pkg::REQ_ENCRYPT, 8'd127, 20'hFFFFF, 20'd0, 20'd0),
                     CHK_MODEL, '0));
    add_row(send_row(mk_req(ecg_pkg::REQ_ENCRYPT, 8'd1, 20'd1, 20'd0, 20'd0), CHK_GIVEN,
                     mk_res(KIND_PAIR, 20'd2, 20'd2, 8'd0)));
    add_row(send_row(mk_req(ecg_pkg::REQ_ENCRYPT, 8'd64, 20'h80000, 20'd0, 20'd0),
                     CHK_MODEL, '0));
    add_row(write_row(ecg_pkg::CFG_PRIVATE, 20'd1048572));
    add_row(send_row(mk_req(ecg_pkg::REQ_DECRYPT, 8'd0, 20'd0, 20'hFFFFF, 20'hFFFFF),
                     CHK_GIVEN, mk_res(KIND_BYTE, 20'd0, 20'd0, 8'd2)));
    add_row(write_row(ecg_pkg::CFG_PRIVATE, 20'd0));
    add_row(send_row(mk_req(ecg_pkg::REQ_DECRYPT, 8'd0, 20'd0, 20'd3, 20'hFFFFF),
                     CHK_MODEL, '0));
    add_row(write_row(ecg_pkg::CFG_PRIVATE, 20'd12345));
    add_row(send_row(mk_req(ecg_pkg::REQ_DECRYPT, 8'd0, 20'd0, 20'hFFFFF, 20'd1),
                     CHK_MODEL, '0));
    add_row(send_row(mk_req(ecg_pkg::REQ_ENCRYPT, 8'd100, 20'h5A5A5, 20'd0, 20'd0),
                     CHK_MODEL, '0));

    foreach (stim_rows[i]) begin
      if (stim_rows[i].kind == ROW_WRITE) begin
        write_register(stim_rows[i].idx, stim_rows[i].value);
      end else begin
        send_request(stim_rows[i].req, 1'b0);
        case (stim_rows[i].chk)
          CHK_MODEL: if (elgamal_answer(stim_rows[i].req, res)) expect_result(res);
          CHK_GIVEN: expect_result(stim_rows[i].given);
          default: ;
        endcase
      end
    end

    for (int set = 0; set < KEY_SETS; set++) begin
      case (set)
        0: begin
          p = 20'd257;
          g = 20'd3;
          x = 20'($urandom_range(1, 255));
        end
        1: begin
          p = 20'd1048573;
          g = 20'd2;
          x = 20'($urandom_range(1, 1048571));
        end
        2: begin
          p = 20'd65537;
          g = 20'd3;
          x = 20'($urandom_range(1, 65535));
        end
        3: begin
          // Arbitrary key words, not necessarily prime or reduced.
          p = 20'($urandom_range(2, 20'hFFFFF));
          g = 20'($urandom);
          x = 20'($urandom);
        end
        4: begin
          p = 20'd1009;
          g = 20'd11;
          x = 20'($urandom_range(0, 1007));
        end
        default: begin
          p = 20'hFFFFF;
          g = 20'hFFFFF;
          x = 20'd0;
        end
      endcase
      if (set == 3)
        y = 20'($urandom);
      else if (set == KEY_SETS - 1)
        y = 20'd0;
      else
        y = 20'(power_mod(64'(g), 64'(x), 64'(p)));
      write_register(ecg_pkg::CFG_MODULUS, p);
      write_register(ecg_pkg::CFG_GENERATOR, g);
      write_register(ecg_pkg::CFG_PUBLIC, y);
      write_register(ecg_pkg::CFG_PRIVATE, x);

      answered = 0;
      while (answered < ANSWERS_PER_SET) begin
        r.req_type      = ecg_pkg::REQ_ENCRYPT;
        r.plain_byte    = 8'($urandom);
        r.nonce         = 20'($urandom);
        r.cipher_first  = 20'($urandom);
        r.cipher_second = 20'($urandom);
        choice = $urandom_range(0, 99);
        if (choice < 45) begin
          r.plain_byte = 8'($urandom_range(1, 127));
          r.nonce      = pick_nonce();
        end else if (choice < 80) begin
          // Decrypt a ciphertext that the current keys would have produced.
          m = 8'($urandom_range(1, 127));
          k = pick_nonce();
          r.req_type      = ecg_pkg::REQ_DECRYPT;
          r.cipher_first  = 20'(power_mod(64'(key_generator), 64'(k),
                                          64'(key_modulus)));
          r.cipher_second = 20'(mul_mod(power_mod(64'(key_public), 64'(k),
                                                  64'(key_modulus)),
                                        64'(m), 64'(key_modulus)));
        end else if (choice < 90) begin
          r.req_type = ecg_pkg::REQ_DECRYPT;
        end else if ($urandom_range(0, 1) == 0) begin
          r.plain_byte = $urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(128, 255));
        end else begin
          r.req_type = ecg_pkg::REQ_DECRYPT;
          if ($urandom_range(0, 1)) r.cipher_first = '0;
          else r.cipher_second = '0;
        end
        send_request(r, $urandom_range(0, 99) < 2);
        if (elgamal_answer(r, res)) begin
          expect_result(res);
          answered++;
        end
      end
    end

    settle();
    if (mismatches == 0 && expected_results.size() == 0)
      $display("tb: PASS");
    else
      $display("tb: FAIL");
    $finish;
  end

endmodule

/* sim.f */
rtl/ecg_pkg.sv
rtl/ecg_mulmod.sv
rtl/ecg_datapath.sv
rtl/ecg_ctrl.sv
rtl/elgamal_cipher_engine_top.sv
tb/tb.sv
